### rtl/core/chr_pkg.sv
// Shared types and codes for the consistent hash ring unit.
// Holds the beat structs, operation and status codes and default sizes.
// No dependencies.
`default_nettype none

package chr_pkg;

    localparam int KEY_W   = 34;
    localparam int NODE_W  = 8;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 7;

    // Default sizes handed to the top level
    localparam int RING_ENTRIES_DEF = 64;
    localparam int MAX_NODES_DEF    = 256;

    // Depth of the command and result queues (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT = 3'd4;

    // Input beat
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [NODE_W-1:0] node_id;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [NODE_W-1:0]  owner_node;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] entry_count;
    } out_item_t;

    // Classified command between front and back
    typedef struct packed {
        logic              is_insert;
        logic              is_remove;
        logic              is_lookup;
        logic [KEY_W-1:0]  key;
        logic [NODE_W-1:0] node;
    } cmd_t;

    // Sequencer status of the back part
    typedef struct packed {
        logic take;
        logic done;
    } back_stat_t;

endpackage

`default_nettype wire

### rtl/core/consistent_hash_ring_unit.sv
// Consistent hash ring unit: insert, remove and lookup on a sorted key ring.
// A taken beat passes the command queue, the registered command and compare
// vectors of the cell chain and the result queue. A new command is taken only
// after the last one has answered: the chain compares all cells, then shifts and answers.
// Reset: queues empty and entry count zero; ring cells are not cleared.
// Depends on chr_pkg, chr_front, chr_back and chr_queue.
`default_nettype none

module consistent_hash_ring_unit
    import chr_pkg::*;
#(
    parameter int RING_ENTRIES = RING_ENTRIES_DEF,
    parameter int MAX_NODES    = MAX_NODES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    cmd_t       cmd;
    logic       cmd_valid;
    logic       cmd_ready;
    logic       res_full;
    logic       res_wr;
    out_item_t  res;
    back_stat_t stat;

    chr_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    chr_back #(
        .RING_ENTRIES (RING_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .res       (res),
        .stat      (stat)
    );

    chr_queue #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

`ifndef SYNTHESIS
    // A command is taken only when the result queue has room
    a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
        stat.take |-> !res_full)
        else $error("command taken with result queue full");

    // Every taken command answers in the next cycle
    a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
        stat.take |=> stat.done)
        else $error("taken command gave no result beat");

    // A result beat is never dropped by a full queue
    a_done_room: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !res_full)
        else $error("result written into a full queue");

    // Only one command in flight
    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.take && stat.done))
        else $error("command taken while another completes");
`endif

endmodule

`default_nettype wire

### rtl/core/chr_queue.sv
// Small first-in first-out queue of flat beats.
// Used for the command and result queues; depends on chr_pkg for its depth.
`default_nettype none

module chr_queue
    import chr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_wr ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/chr_front.sv
// Front part: accepts input beats, decodes the operation, folds the node id
// into range and queues the command. Depends on chr_pkg and chr_queue.
`default_nettype none

module chr_front
    import chr_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    // The node id field only needs folding when MAX_NODES is below its span
    localparam bit NODE_WRAP = (MAX_NODES < (1 << NODE_W));
    localparam int DIVISOR   = NODE_WRAP ? MAX_NODES : 2;
    localparam int RECIP_SH  = 16;
    localparam int PROD_W    = NODE_W + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RECIP =
        RECIP_SH'(((1 << RECIP_SH) + DIVISOR - 1) / DIVISOR);
    localparam logic [NODE_W-1:0] DIV_C = NODE_W'(DIVISOR);

    cmd_t              cmd_in;
    logic              cmd_empty;
    logic [PROD_W-1:0] prod;
    logic [NODE_W-1:0] quot;
    logic [NODE_W-1:0] node_mod;

    // Reduce node id modulo MAX_NODES by reciprocal multiplication
    always_comb
    begin
        prod     = PROD_W'(item.node_id) * PROD_W'(RECIP);
        quot     = prod[PROD_W-1:RECIP_SH];
        node_mod = item.node_id;
        if (NODE_WRAP)
        begin
            node_mod = item.node_id - NODE_W'(quot * DIV_C);
        end
    end

    // Classify the operation
    always_comb
    begin
        cmd_in.is_insert = (item.func == FUNC_INSERT);
        cmd_in.is_remove = (item.func == FUNC_REMOVE);
        cmd_in.is_lookup = (item.func == FUNC_LOOKUP);
        cmd_in.key       = item.key;
        cmd_in.node      = node_mod;
    end

    chr_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_ready),
        .rd_data (cmd),
        .empty   (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

### rtl/core/chr_back.sv
// Back part: sorted cell chain of ring keys and owners with a two-step
// sequencer (compare, then update and answer). Depends on chr_pkg.
`default_nettype none

module chr_back
    import chr_pkg::*;
#(
    parameter int RING_ENTRIES = RING_ENTRIES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    input  wire logic res_full,
    output logic      res_wr,
    output out_item_t res,
    output back_stat_t stat
);

    localparam int N      = RING_ENTRIES;
    localparam int FILL_W = $clog2(N + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic              state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    cmd_t              op_reg;
    logic [N-1:0]      lt_reg, lt_next;
    logic [N-1:0]      eq_reg, eq_next;
    logic [KEY_W-1:0]  key_reg [N];
    logic [KEY_W-1:0]  key_next [N];
    logic [NODE_W-1:0] own_reg [N];
    logic [NODE_W-1:0] own_next [N];

    logic [N-1:0]      valid_vec;
    logic [N-1:0]      lt_prev;
    logic [N-1:0]      first_vec;
    logic [N-1:0]      hit_vec;
    logic              take;
    logic              dup;
    logic              do_ins;
    logic              do_rem;
    logic [NODE_W-1:0] owner_sel;
    logic [STAT_W-1:0] status_sel;
    logic [NODE_W-1:0] owner_out;

    assign cmd_ready = (state_reg == S_IDLE) && !res_full;
    assign take      = cmd_valid && cmd_ready;

    // Compare every cell against the incoming key
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            valid_vec[i] = (FILL_W'(i) < fill_reg);
            lt_next[i]   = valid_vec[i] && (key_reg[i] < cmd.key);
            eq_next[i]   = valid_vec[i] && (key_reg[i] == cmd.key);
        end
    end

    // Locate the insertion point and the owner it selects
    always_comb
    begin
        if (N > 1)
        begin
            lt_prev = {lt_reg[N-2:0], 1'b1};
        end
        else
        begin
            lt_prev = '1;
        end
        first_vec = ~lt_reg & lt_prev;
        hit_vec   = first_vec & valid_vec;
        dup       = |eq_reg;
        owner_sel = '0;
        for (int i = 0; i < N; i++)
        begin
            owner_sel = owner_sel | (hit_vec[i] ? own_reg[i] : '0);
        end
        // Wrap to the smallest key when nothing is at or above the query
        if (!(|hit_vec))
        begin
            owner_sel = own_reg[0];
        end
    end

    // Decide the outcome of the operation
    always_comb
    begin
        do_ins     = 1'b0;
        do_rem     = 1'b0;
        status_sel = ST_OK;
        owner_out  = '0;
        fill_next  = fill_reg;
        if (op_reg.is_insert)
        begin
            if (dup)
            begin
                status_sel = ST_DUP;
            end
            else if (fill_reg == FILL_W'(N))
            begin
                status_sel = ST_FULL;
            end
            else
            begin
                do_ins    = 1'b1;
                fill_next = FILL_W'(fill_reg + 1'b1);
            end
        end
        else if (op_reg.is_remove)
        begin
            if (dup)
            begin
                do_rem    = 1'b1;
                fill_next = FILL_W'(fill_reg - 1'b1);
            end
            else
            begin
                status_sel = ST_ABSENT;
            end
        end
        else if (op_reg.is_lookup)
        begin
            if (fill_reg == '0)
            begin
                status_sel = ST_EMPTY;
            end
            else
            begin
                owner_out = owner_sel;
            end
        end
        if (state_reg != S_EXEC)
        begin
            do_ins    = 1'b0;
            do_rem    = 1'b0;
            fill_next = fill_reg;
        end
    end

    // Shift cells up on insert, down on remove, otherwise hold
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            key_next[i] = key_reg[i];
            own_next[i] = own_reg[i];
        end
        if (do_ins)
        begin
            if (first_vec[0])
            begin
                key_next[0] = op_reg.key;
                own_next[0] = op_reg.node;
            end
            for (int i = 1; i < N; i++)
            begin
                if (first_vec[i])
                begin
                    key_next[i] = op_reg.key;
                    own_next[i] = op_reg.node;
                end
                else if (!lt_reg[i])
                begin
                    key_next[i] = key_reg[i-1];
                    own_next[i] = own_reg[i-1];
                end
            end
        end
        else if (do_rem)
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                if (!lt_reg[i])
                begin
                    key_next[i] = key_reg[i+1];
                    own_next[i] = own_reg[i+1];
                end
            end
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    // Latch the command and the compare vectors
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= cmd;
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    // Hold the ring cells
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            key_reg[i] <= key_next[i];
            own_reg[i] <= own_next[i];
        end
    end

    assign res_wr          = (state_reg == S_EXEC);
    assign res.owner_node  = owner_out;
    assign res.status      = status_sel;
    assign res.entry_count = COUNT_W'(fill_next);

    assign stat.take = take;
    assign stat.done = res_wr;

endmodule

`default_nettype wire

### tb/sv/consistent_hash_ring_unit_test.sv
// Self-checking testbench for consistent_hash_ring_unit: directed probes, then
// random grow and shrink phases checked against a sorted-ring predictor.
// Depends on chr_pkg and the consistent_hash_ring_unit RTL.
`timescale 1ns / 1ps

module consistent_hash_ring_unit_test;
    import chr_pkg::*;

    localparam int RING_SLOTS   = RING_ENTRIES_DEF;
    localparam int NODE_SPAN    = MAX_NODES_DEF;
    localparam int RANDOM_ITEMS = 1330;
    localparam int CALM_ITEMS   = 120;
    localparam int DRAIN_CYCLES = 12;
    localparam int STUCK_LIMIT  = 2000;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam logic [KEY_W-1:0]  KEY_TOP    = {KEY_W{1'b1}};

    typedef struct {
        in_item_t  beat;
        bit        typed;
        out_item_t answer;
    } probe_row_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    in_item_t  item  = '0;
    logic      full;
    logic      empty;
    out_item_t result;

    // Predictor copy of the ring
    logic [KEY_W-1:0]  ring_key_q [RING_SLOTS];
    logic [NODE_W-1:0] ring_own_q [RING_SLOTS];
    int                ring_fill = 0;

    out_item_t  owed_results[$];
    probe_row_t probe_rows[$];
    int         mismatch_count = 0;
    int         stuck_cycles   = 0;
    bit         calm           = 1'b0;

    consistent_hash_ring_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #10 clk = ~clk;

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Apply one operation to the predicted ring and return its answer
    function automatic out_item_t apply_ring_op(in_item_t beat);
        out_item_t answer;
        int        pos;
        int        j;
        answer = '0;
        answer.status = ST_OK;
        pos = 0;
        while (pos < ring_fill && ring_key_q[pos] < beat.key)
            pos++;
        case (beat.func)
            FUNC_INSERT:
            begin
                if (pos < ring_fill && ring_key_q[pos] == beat.key)
                    answer.status = ST_DUP;
                else if (ring_fill >= RING_SLOTS)
                    answer.status = ST_FULL;
                else
                begin
                    for (j = ring_fill; j > pos; j--)
                    begin
                        ring_key_q[j] = ring_key_q[j-1];
                        ring_own_q[j] = ring_own_q[j-1];
                    end
                    ring_key_q[pos] = beat.key;
                    ring_own_q[pos] = NODE_W'(int'(beat.node_id) % NODE_SPAN);
                    ring_fill++;
                end
            end
            FUNC_REMOVE:
            begin
                if (pos < ring_fill && ring_key_q[pos] == beat.key)
                begin
                    for (j = pos; j + 1 < ring_fill; j++)
                    begin
                        ring_key_q[j] = ring_key_q[j+1];
                        ring_own_q[j] = ring_own_q[j+1];
                    end
                    ring_fill--;
                end
                else
                    answer.status = ST_ABSENT;
            end
            FUNC_LOOKUP:
            begin
                if (ring_fill == 0)
                    answer.status = ST_EMPTY;
                else
                begin
                    // wrap to the smallest key when nothing lies at or above
                    if (pos >= ring_fill)
                        pos = 0;
                    answer.owner_node = ring_own_q[pos];
                end
            end
            default: ;
        endcase
        answer.entry_count = COUNT_W'(ring_fill);
        return answer;
    endfunction

    function automatic logic [KEY_W-1:0] any_key();
        logic [KEY_W-1:0] k;
        k[KEY_W-1:32] = 2'($urandom_range(0, 3));
        k[31:0]       = $urandom;
        return k;
    endfunction

    // Pick a stored key, or a random one while the ring is empty
    function automatic logic [KEY_W-1:0] stored_key();
        if (ring_fill == 0)
            return any_key();
        return ring_key_q[$urandom_range(0, ring_fill - 1)];
    endfunction

    // Random operation, biased towards growing or draining the ring
    function automatic in_item_t random_ring_op(bit growing);
        in_item_t beat;
        int       r;
        int       pick;
        beat.node_id = NODE_W'($urandom);
        beat.key     = '0;
        r = $urandom_range(0, 99);
        if (growing)
        begin
            if (r < 60)
            begin
                beat.func = FUNC_INSERT;
                beat.key  = any_key();
            end
            else if (r < 70)
            begin
                beat.func = FUNC_INSERT;
                beat.key  = stored_key();
            end
            else if (r < 78)
            begin
                beat.func = FUNC_REMOVE;
                beat.key  = stored_key();
            end
            else if (r < 82)
            begin
                beat.func = FUNC_REMOVE;
                beat.key  = any_key();
            end
            else if (r < 97)
                beat.func = FUNC_LOOKUP;
            else
            begin
                beat.func = FUNC_SPARE;
                beat.key  = any_key();
            end
        end
        else
        begin
            if (r < 50)
            begin
                beat.func = FUNC_REMOVE;
                beat.key  = stored_key();
            end
            else if (r < 58)
            begin
                beat.func = FUNC_REMOVE;
                beat.key  = any_key();
            end
            else if (r < 68)
            begin
                beat.func = FUNC_INSERT;
                beat.key  = any_key();
            end
            else if (r < 72)
            begin
                beat.func = FUNC_INSERT;
                beat.key  = stored_key();
            end
            else if (r < 96)
                beat.func = FUNC_LOOKUP;
            else
            begin
                beat.func = FUNC_SPARE;
                beat.key  = any_key();
            end
        end
        // lookups probe random keys, stored keys and their neighbours, and the ends of the key space
        if (beat.func == FUNC_LOOKUP)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)      beat.key = any_key();
            else if (pick < 6) beat.key = stored_key();
            else if (pick < 8) beat.key = stored_key() + KEY_W'(1);
            else if (pick < 9) beat.key = stored_key() - KEY_W'(1);
            else               beat.key = $urandom_range(0, 1) ? KEY_TOP : '0;
        end
        return beat;
    endfunction

    task automatic add_probe(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                             logic [NODE_W-1:0] n, bit typed,
                             logic [NODE_W-1:0] own, logic [STAT_W-1:0] st,
                             logic [COUNT_W-1:0] cnt);
        probe_row_t row;
        row.beat.func          = f;
        row.beat.key           = k;
        row.beat.node_id       = n;
        row.typed              = typed;
        row.answer.owner_node  = own;
        row.answer.status      = st;
        row.answer.entry_count = cnt;
        probe_rows.push_back(row);
    endtask

    task automatic report_field(string label, longint unsigned want,
                                longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Stimulus: directed probes, then random phases
    initial
    begin : drive
        in_item_t  next_beat;
        out_item_t want;
        int        total;
        int        n;
        int        rows;
        bit        growing;
        int        full_hits;
        int        empty_hits;

        // empty ring, extremes of the key, duplicates, wrap-around and misses
        add_probe(FUNC_LOOKUP, '0,      8'h00, 1, 8'h00, ST_EMPTY,  7'd0);
        add_probe(FUNC_REMOVE, KEY_TOP, 8'h00, 1, 8'h00, ST_ABSENT, 7'd0);
        add_probe(FUNC_SPARE,  KEY_TOP, 8'hFF, 1, 8'h00, ST_OK,     7'd0);
        add_probe(FUNC_INSERT, KEY_TOP, 8'hFF, 1, 8'h00, ST_OK,     7'd1);
        add_probe(FUNC_INSERT, KEY_TOP, 8'h01, 1, 8'h00, ST_DUP,    7'd1);
        add_probe(FUNC_LOOKUP, '0,      8'h00, 1, 8'hFF, ST_OK,     7'd1);
        add_probe(FUNC_LOOKUP, KEY_TOP, 8'h00, 1, 8'hFF, ST_OK,     7'd1);
        add_probe(FUNC_INSERT, '0,      8'h00, 1, 8'h00, ST_OK,     7'd2);
        add_probe(FUNC_LOOKUP, '0,      8'hFF, 1, 8'h00, ST_OK,     7'd2);
        add_probe(FUNC_LOOKUP, 34'h1,   8'h00, 1, 8'hFF, ST_OK,     7'd2);
        add_probe(FUNC_INSERT, 34'h2AAAAAAAA, 8'hAA, 0, '0, ST_OK, '0);
        add_probe(FUNC_INSERT, 34'h155555555, 8'h55, 0, '0, ST_OK, '0);
        add_probe(FUNC_LOOKUP, 34'h155555556, 8'h00, 0, '0, ST_OK, '0);
        add_probe(FUNC_LOOKUP, 34'h2AAAAAAAB, 8'h00, 0, '0, ST_OK, '0);
        add_probe(FUNC_REMOVE, KEY_TOP,       8'h00, 0, '0, ST_OK, '0);
        add_probe(FUNC_LOOKUP, 34'h300000000, 8'h00, 0, '0, ST_OK, '0);
        add_probe(FUNC_REMOVE, 34'h155555555, 8'h00, 0, '0, ST_OK, '0);
        add_probe(FUNC_REMOVE, 34'h155555555, 8'h00, 1, 8'h00, ST_ABSENT, 7'd2);
        add_probe(FUNC_SPARE,  '0,            8'h00, 0, '0, ST_OK, '0);
        add_probe(FUNC_REMOVE, '0,            8'h00, 0, '0, ST_OK, '0);
        add_probe(FUNC_REMOVE, 34'h2AAAAAAAA, 8'h00, 0, '0, ST_OK, '0);
        add_probe(FUNC_LOOKUP, KEY_TOP,       8'h00, 1, 8'h00, ST_EMPTY, 7'd0);

        rows       = probe_rows.size();
        total      = rows + RANDOM_ITEMS;
        growing    = 1'b1;
        full_hits  = 0;
        empty_hits = 0;
        while (!rst_n)
            @(posedge clk);

        for (n = 0; n < total; n++)
        begin
            // switch phase once the ring has sat full or empty for a while
            if (growing && ring_fill == RING_SLOTS && ++full_hits > 12)
            begin
                growing   = 1'b0;
                full_hits = 0;
            end
            else if (!growing && ring_fill == 0 && ++empty_hits > 6)
            begin
                growing    = 1'b1;
                empty_hits = 0;
            end
            next_beat = (n < rows) ? probe_rows[n].beat : random_ring_op(growing);
            calm = (n >= total - CALM_ITEMS);

            // hold off the sender for a short burst now and then
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            push <= 1'b1;
            item <= next_beat;
            @(posedge clk);
            while (full)
                @(posedge clk);

            want = apply_ring_op(next_beat);
            if (n < rows && probe_rows[n].typed)
                want = probe_rows[n].answer;
            owed_results.push_back(want);
        end
        push <= 1'b0;

        // drain, then let the pipeline settle
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Results: check each popped beat, stall the reader in random bursts
    initial
    begin : collect
        int        stall_left;
        out_item_t want;
        stall_left = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, result);
                    mismatch_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    report_field("owner_node", want.owner_node, result.owner_node);
                    report_field("status", want.status, result.status);
                    report_field("entry_count", want.entry_count, result.entry_count);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: watchdog: no beat moved for %0d cycles, %0d results owed",
                         $time, stuck_cycles, owed_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
